[rtl/core/lpmd_pkg.sv]
// ----------------------------------------------------------------------------
// lpmd_pkg
// types, codes and sizes shared by the message deframer files
// ----------------------------------------------------------------------------
package lpmd_pkg;

    // width of the decoded length registers (8 to 32)
    localparam int LENGTH_WIDTH = 32;
    localparam int TYPE_WIDTH   = 16;
    localparam int FIELD_WIDTH  = 32;
    localparam int SEEN_WIDTH   = 4;

    // smallest well-formed message in bytes
    localparam logic [SEEN_WIDTH-1:0] MIN_BYTES = SEEN_WIDTH'(10);

    localparam logic [LENGTH_WIDTH-1:0] TYPE_BYTES = LENGTH_WIDTH'(2);
    localparam logic [LENGTH_WIDTH-1:0] LEN_BYTES  = LENGTH_WIDTH'(4);

    typedef logic [LENGTH_WIDTH-1:0] t_len;

    // parse phase, one-hot
    typedef enum logic [5:0] {
        PH_TYPE    = 6'b000001,
        PH_NLEN    = 6'b000010,
        PH_NAME    = 6'b000100,
        PH_PLEN    = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_TRAIL   = 6'b100000
    } t_phase;

    typedef enum logic [2:0] {
        RG_TYPE    = 3'd0,
        RG_NLEN    = 3'd1,
        RG_NAME    = 3'd2,
        RG_PLEN    = 3'd3,
        RG_PAYLOAD = 3'd4,
        RG_TRAIL   = 3'd5
    } t_region;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_NAME_OVR = 2'd2,
        ST_PAY_OVR  = 2'd3
    } t_status;

    // one input word moving into the parser
    typedef struct packed {
        logic       fire;
        logic [7:0] in_byte;
        logic       last;
    } t_step;

    // one tagged output word
    typedef struct packed {
        logic [7:0]             out_byte;
        t_region                region;
        logic [TYPE_WIDTH-1:0]  message_type;
        logic [FIELD_WIDTH-1:0] name_length;
        logic [FIELD_WIDTH-1:0] payload_length;
        logic                   done_res;
        t_status                status;
    } t_result;

    function automatic t_region phase_region(input t_phase ph);
        t_region rg;
        case (ph)
            PH_TYPE:    rg = RG_TYPE;
            PH_NLEN:    rg = RG_NLEN;
            PH_NAME:    rg = RG_NAME;
            PH_PLEN:    rg = RG_PLEN;
            PH_PAYLOAD: rg = RG_PAYLOAD;
            default:    rg = RG_TRAIL;
        endcase
        return rg;
    endfunction

endpackage

[rtl/core/lpmd_in_if.sv]
// ----------------------------------------------------------------------------
// lpmd_in_if
// input byte channel: valid/ready with one message byte and its end flag
// ----------------------------------------------------------------------------
interface lpmd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last;

    modport source (output valid, output in_byte, output last, input ready);
    modport sink   (input valid, input in_byte, input last, output ready);
endinterface

[rtl/core/lpmd_out_if.sv]
// ----------------------------------------------------------------------------
// lpmd_out_if
// output channel: valid/ready with a tagged byte, decoded fields and status
// ----------------------------------------------------------------------------
interface lpmd_out_if;
    logic                              valid;
    logic                              ready;
    logic [7:0]                        out_byte;
    logic [2:0]                        region;
    logic [lpmd_pkg::TYPE_WIDTH-1:0]   message_type;
    logic [lpmd_pkg::FIELD_WIDTH-1:0]  name_length;
    logic [lpmd_pkg::FIELD_WIDTH-1:0]  payload_length;
    logic                              done_res;
    logic [1:0]                        status;

    modport source (output valid, output out_byte, output region, output message_type,
                    output name_length, output payload_length, output done_res,
                    output status, input ready);
    modport sink   (input valid, input out_byte, input region, input message_type,
                    input name_length, input payload_length, input done_res,
                    input status, output ready);
endinterface

[rtl/core/lpmd_parse.sv]
// ----------------------------------------------------------------------------
// lpmd_parse
// framing state and field assembly, one word per step
// ----------------------------------------------------------------------------
module lpmd_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpmd_pkg::t_step   i_step,
    output lpmd_pkg::t_result o_res
);

    lpmd_pkg::t_phase                    r_phase, n_phase;
    lpmd_pkg::t_len                      r_remaining, n_remaining;
    logic [lpmd_pkg::SEEN_WIDTH-1:0]     r_seen, n_seen;
    logic [lpmd_pkg::TYPE_WIDTH-1:0]     r_type, n_type;
    lpmd_pkg::t_len                      r_nlen, n_nlen;
    lpmd_pkg::t_len                      r_plen, n_plen;

    lpmd_pkg::t_phase  cur_phase;
    lpmd_pkg::t_len    rem_dec;
    lpmd_pkg::t_status status;

    always_comb begin
        // codes that are not a legal phase behave as trailing
        case (r_phase)
            lpmd_pkg::PH_TYPE, lpmd_pkg::PH_NLEN, lpmd_pkg::PH_NAME,
            lpmd_pkg::PH_PLEN, lpmd_pkg::PH_PAYLOAD: cur_phase = r_phase;
            default:                                 cur_phase = lpmd_pkg::PH_TRAIL;
        endcase

        n_seen = (r_seen < lpmd_pkg::MIN_BYTES) ? r_seen + 1'b1 : r_seen;
        n_type = r_type;
        n_nlen = r_nlen;
        n_plen = r_plen;

        // big-endian shift-in of the current field
        case (cur_phase)
            lpmd_pkg::PH_TYPE: n_type = {r_type[7:0], i_step.in_byte};
            lpmd_pkg::PH_NLEN: n_nlen = lpmd_pkg::t_len'({r_nlen, i_step.in_byte});
            lpmd_pkg::PH_PLEN: n_plen = lpmd_pkg::t_len'({r_plen, i_step.in_byte});
            default: ;
        endcase

        rem_dec     = (r_remaining != '0) ? r_remaining - 1'b1 : r_remaining;
        n_phase     = cur_phase;
        n_remaining = r_remaining;

        if (cur_phase != lpmd_pkg::PH_TRAIL) begin
            n_remaining = rem_dec;
            if (rem_dec == '0) begin
                case (cur_phase)
                    lpmd_pkg::PH_TYPE: begin
                        n_phase     = lpmd_pkg::PH_NLEN;
                        n_remaining = lpmd_pkg::LEN_BYTES;
                    end
                    lpmd_pkg::PH_NLEN: begin
                        if (n_nlen == '0) begin
                            n_phase     = lpmd_pkg::PH_PLEN;
                            n_remaining = lpmd_pkg::LEN_BYTES;
                        end else begin
                            n_phase     = lpmd_pkg::PH_NAME;
                            n_remaining = n_nlen;
                        end
                    end
                    lpmd_pkg::PH_NAME: begin
                        n_phase     = lpmd_pkg::PH_PLEN;
                        n_remaining = lpmd_pkg::LEN_BYTES;
                    end
                    lpmd_pkg::PH_PLEN: begin
                        if (n_plen == '0) begin
                            n_phase = lpmd_pkg::PH_TRAIL;
                        end else begin
                            n_phase     = lpmd_pkg::PH_PAYLOAD;
                            n_remaining = n_plen;
                        end
                    end
                    default: n_phase = lpmd_pkg::PH_TRAIL;
                endcase
            end
        end

        // end-of-message verdict, judged on the phase after this byte
        status = lpmd_pkg::ST_OK;
        if (i_step.last) begin
            if (n_seen < lpmd_pkg::MIN_BYTES ||
                n_phase inside {lpmd_pkg::PH_TYPE, lpmd_pkg::PH_NLEN}) begin
                status = lpmd_pkg::ST_SHORT;
            end else if (n_phase == lpmd_pkg::PH_NAME) begin
                status = lpmd_pkg::ST_NAME_OVR;
            end else if (n_phase inside {lpmd_pkg::PH_PLEN, lpmd_pkg::PH_PAYLOAD}) begin
                status = lpmd_pkg::ST_PAY_OVR;
            end
        end

        o_res.out_byte       = i_step.in_byte;
        o_res.region         = lpmd_pkg::phase_region(cur_phase);
        o_res.message_type   = n_type;
        o_res.name_length    = lpmd_pkg::FIELD_WIDTH'(n_nlen);
        o_res.payload_length = lpmd_pkg::FIELD_WIDTH'(n_plen);
        o_res.done_res       = i_step.last;
        o_res.status         = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step.fire && i_step.last)) begin
            r_phase     <= lpmd_pkg::PH_TYPE;
            r_remaining <= lpmd_pkg::TYPE_BYTES;
            r_seen      <= '0;
            r_type      <= '0;
            r_nlen      <= '0;
            r_plen      <= '0;
        end else if (i_step.fire) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_seen      <= n_seen;
            r_type      <= n_type;
            r_nlen      <= n_nlen;
            r_plen      <= n_plen;
        end
    end

    // a finished message leaves the parser at the start of the type field
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step.fire && i_step.last) |=> (r_phase == lpmd_pkg::PH_TYPE && r_seen == '0))
        else $error("parser not rewound after final byte");

    // the byte counter never passes the minimum length
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= lpmd_pkg::MIN_BYTES)
        else $error("seen count beyond saturation");

    // only the trailing phase may sit with nothing left to count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_remaining == '0) |-> (r_phase == lpmd_pkg::PH_TRAIL))
        else $error("empty count outside trailing phase");

endmodule

[rtl/core/length_prefixed_message_deframer.sv]
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer
// tags each message byte with its region, decoded type and lengths, and
// reports a status on the final byte
// ----------------------------------------------------------------------------
// a word accepted at the input passes the input register and then the result
// register; throughput is one byte per cycle while the sink keeps ready high,
// set by the single-step field/phase update
// while a result waits the empty input register can still take one word
// reset (i_rst_n low, synchronous) empties both registers and rewinds the
// parser to the type field with all decoded fields at zero
module length_prefixed_message_deframer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lpmd_in_if.sink       i_in,
    lpmd_out_if.source    o_out
);

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // result register
    logic              r_out_vld;
    lpmd_pkg::t_result r_res;

    lpmd_pkg::t_step   step;
    lpmd_pkg::t_result res;

    logic advance;
    logic in_fire;

    // the held word moves on when the result slot is free or being drained
    assign advance = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || advance;
    assign in_fire = i_in.valid && i_in.ready;

    assign step.fire    = advance;
    assign step.in_byte = r_in_byte;
    assign step.last    = r_in_last;

    lpmd_parse u_parse (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (step),
        .o_res  (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_fire) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    // payload of the input register needs no reset
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= i_in.in_byte;
            r_in_last <= i_in.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= res;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.out_byte       = r_res.out_byte;
    assign o_out.region         = r_res.region;
    assign o_out.message_type   = r_res.message_type;
    assign o_out.name_length    = r_res.name_length;
    assign o_out.payload_length = r_res.payload_length;
    assign o_out.done_res       = r_res.done_res;
    assign o_out.status         = r_res.status;

    // an empty input register always takes a word
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |-> i_in.ready)
        else $error("input stalled with an empty input register");

    // a status other than ok only on the final word of a message
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_res.done_res) |-> (r_res.status == lpmd_pkg::ST_OK))
        else $error("status raised on a word that does not end the message");

    // a held word with a free result slot moves on at once
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !r_out_vld) |=> r_out_vld)
        else $error("held word not moved into a free result register");

    // a trailing-region word means the header was complete
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_res.region == lpmd_pkg::RG_TRAIL && r_res.done_res)
            |-> (r_res.status == lpmd_pkg::ST_OK || r_res.status == lpmd_pkg::ST_SHORT))
        else $error("overrun reported after the payload ended");

endmodule
